FILE: hw/rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free-list id allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    // field widths fixed by the item format
    localparam int unsigned MODE_W = 2;
    localparam int unsigned ID_W   = 11;
    localparam int unsigned EB_W   = 16;
    localparam int unsigned OFF_W  = 26;

    // reset value of the element size register
    localparam logic [EB_W-1:0] EB_RESET = 16'd4;

    // request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_LOOKUP  = 2'd2
    } t_mode;

    // control sequencer states
    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

endpackage

FILE: hw/rtl/fla_req_if.sv
// ----------------------------------------------------------------------------
// fla_req_if
// Request channel of the allocator: mode and slot id with valid/ready.
// ----------------------------------------------------------------------------
interface fla_req_if;

    logic                         valid;
    logic                         ready;
    logic [fla_pkg::MODE_W-1:0]   mode;
    logic [fla_pkg::ID_W-1:0]     slot_id;

    modport source (output valid, output mode, output slot_id, input ready);
    modport sink   (input valid, input mode, input slot_id, output ready);

endinterface

FILE: hw/rtl/fla_rsp_if.sv
// ----------------------------------------------------------------------------
// fla_rsp_if
// Response channel of the allocator: granted id, byte offset, ok flag.
// ----------------------------------------------------------------------------
interface fla_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [fla_pkg::ID_W-1:0]    granted_id;
    logic [fla_pkg::OFF_W-1:0]   byte_offset;
    logic                        ok;

    modport source (output valid, output granted_id, output byte_offset, output ok,
                    input ready);
    modport sink   (input valid, input granted_id, input byte_offset, input ok,
                    output ready);

endinterface

FILE: hw/rtl/free_list_id_allocator.sv
// ----------------------------------------------------------------------------
// free_list_id_allocator
// Hands out 1-based slot ids from a fixed pool through a LIFO free list kept
// in a link memory, with a bump count for slots never handed out before.
// ----------------------------------------------------------------------------
// Usage:
//   i_req transfers a request (create, destroy or lookup); o_rsp returns one
//   response per request, in order. i_cfg_we/i_cfg_wdata set the element
//   size in bytes and must only be written while the block is idle.
// Response path and throughput:
//   destroy, lookup and a create served by the bump count register their
//   response at the transfer edge, and a new request can be taken every
//   cycle while the receiver keeps up and no pop is under way.
//   a create that pops the free list first passes through S_POP: the link
//   memory has a registered read, and the new list head comes from it.
//   the lookup offset is one 11x16 multiply ahead of the output register.
// Reset:
//   free list empty, bump count zero, element size 4. The link memory is not
//   cleared; only entries written by a destroy are ever followed.
// Stall:
//   a response waits in the output register; a new request is taken in the
//   same cycle the waiting response transfers, otherwise i_req.ready is low.
// ----------------------------------------------------------------------------
module free_list_id_allocator #(
    parameter int unsigned POOL_SLOTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fla_pkg::EB_W-1:0]   i_cfg_wdata,
    fla_req_if.sink                    i_req,
    fla_rsp_if.source                  o_rsp
);

    localparam int unsigned AW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int unsigned CMP_W = 18;
    localparam int unsigned MUL_W = fla_pkg::ID_W + fla_pkg::EB_W;

    // link memory: next free id for each slot, 0 ends the list
    logic [fla_pkg::ID_W-1:0] r_link [POOL_SLOTS];
    logic [fla_pkg::ID_W-1:0] r_link_q;

    fla_pkg::t_state            r_state, n_state;
    logic [fla_pkg::ID_W-1:0]   r_free_head, n_free_head;
    logic [fla_pkg::ID_W-1:0]   r_high_water, n_high_water;
    logic [fla_pkg::EB_W-1:0]   r_elem_bytes;
    logic                       r_out_valid, n_out_valid;
    logic [fla_pkg::ID_W-1:0]   r_granted, n_granted;
    logic [fla_pkg::OFF_W-1:0]  r_offset, n_offset;
    logic                       r_ok, n_ok;

    logic                       w_accept;
    logic                       w_in_range;
    logic                       w_link_we;
    logic [AW-1:0]              w_link_waddr;
    logic [AW-1:0]              w_link_raddr;
    logic [fla_pkg::ID_W-1:0]   w_id_m1;
    logic [fla_pkg::ID_W-1:0]   w_head_m1;
    logic [MUL_W-1:0]           w_product;
    logic                       w_pool_left;

    // handshake
    assign i_req.ready = (r_state == fla_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted_id  = r_granted;
    assign o_rsp.byte_offset = r_offset;
    assign o_rsp.ok          = r_ok;

    // id decode and range check
    assign w_id_m1     = i_req.slot_id - fla_pkg::ID_W'(1);
    assign w_head_m1   = r_free_head - fla_pkg::ID_W'(1);
    assign w_in_range  = (i_req.slot_id != '0) && (i_req.slot_id <= r_high_water);
    assign w_pool_left = CMP_W'(r_high_water) < CMP_W'(POOL_SLOTS);
    assign w_product   = MUL_W'(w_id_m1) * MUL_W'(r_elem_bytes);

    // link memory addresses: read always follows the list head
    assign w_link_waddr = AW'(w_id_m1);
    assign w_link_raddr = AW'(w_head_m1);

    // next state, list update and response
    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_granted    = r_granted;
        n_offset     = r_offset;
        n_ok         = r_ok;
        w_link_we    = 1'b0;
        unique case (r_state)
            fla_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_granted = '0;
                    n_offset  = '0;
                    n_ok      = 1'b0;
                    unique case (i_req.mode)
                        fla_pkg::MODE_CREATE: begin
                            priority if (r_free_head != '0) begin
                                // pop waits in S_POP for the link read
                                n_state     = fla_pkg::S_POP;
                                n_out_valid = 1'b0;
                            end else if (w_pool_left) begin
                                n_high_water = r_high_water + fla_pkg::ID_W'(1);
                                n_granted    = r_high_water + fla_pkg::ID_W'(1);
                                n_ok         = 1'b1;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        fla_pkg::MODE_DESTROY: begin
                            if (w_in_range) begin
                                w_link_we   = 1'b1;
                                n_free_head = i_req.slot_id;
                                n_ok        = 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        fla_pkg::MODE_LOOKUP: begin
                            if (w_in_range) begin
                                n_offset = w_product[fla_pkg::OFF_W-1:0];
                                n_ok     = 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            fla_pkg::S_POP: begin
                n_granted   = r_free_head;
                n_offset    = '0;
                n_ok        = 1'b1;
                n_out_valid = 1'b1;
                n_free_head = r_link_q;
                n_state     = fla_pkg::S_IDLE;
            end
            default: begin
                n_state = fla_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fla_pkg::S_IDLE;
            r_free_head  <= '0;
            r_high_water <= '0;
            r_elem_bytes <= fla_pkg::EB_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_high_water <= n_high_water;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_elem_bytes <= i_cfg_wdata;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_offset  <= n_offset;
        r_ok      <= n_ok;
    end

    // link memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link[w_link_waddr] <= r_free_head;
        end
        r_link_q <= r_link[w_link_raddr];
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the free-list id allocator against an in-bench model of its free
// list, bump count and element size. Random idling on both channels, with
// directed corner cases and random create/destroy/lookup traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned POOL     = 1024;
    localparam int unsigned ID_MAX   = (1 << fla_pkg::ID_W) - 1;
    localparam int unsigned EB_MAX   = (1 << fla_pkg::EB_W) - 1;

    // request code the block does not define
    localparam logic [fla_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one response as the block returns it
    typedef struct packed {
        logic [fla_pkg::ID_W-1:0]  granted_id;
        logic [fla_pkg::OFF_W-1:0] byte_offset;
        logic                      ok;
    } t_alloc_rsp;

    // model of the allocator plus the queue of responses still owed
    class alloc_scoreboard;
        logic [fla_pkg::EB_W-1:0] elem_bytes;
        logic [fla_pkg::ID_W-1:0] link_mem [POOL];
        logic [fla_pkg::ID_W-1:0] free_head;
        logic [fla_pkg::ID_W-1:0] high_water;
        t_alloc_rsp               owed_q[$];
        int                       n_fail;

        function new();
            elem_bytes = fla_pkg::EB_RESET;
            free_head  = '0;
            high_water = '0;
            n_fail     = 0;
            foreach (link_mem[i]) link_mem[i] = '0;
        endfunction

        function void set_elem_bytes(logic [fla_pkg::EB_W-1:0] v);
            elem_bytes = v;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        function void note_failure(string msg);
            n_fail++;
            if (n_fail <= 10) $display("mismatch: %s", msg);
        endfunction

        // apply one accepted request and queue the response it owes
        function t_alloc_rsp note_request(logic [fla_pkg::MODE_W-1:0] mode,
                                          logic [fla_pkg::ID_W-1:0] id);
            t_alloc_rsp  r;
            int unsigned prod;
            bit          id_ok;
            r     = '0;
            id_ok = (id >= 1) && (id <= high_water);
            case (mode)
                fla_pkg::MODE_CREATE: begin
                    if (free_head != 0) begin
                        r.granted_id = free_head;
                        free_head    = link_mem[free_head - 1];
                        r.ok         = 1'b1;
                    end else if (high_water < POOL) begin
                        high_water   = high_water + 1'b1;
                        r.granted_id = high_water;
                        r.ok         = 1'b1;
                    end
                end
                fla_pkg::MODE_DESTROY: begin
                    if (id_ok) begin
                        link_mem[id - 1] = free_head;
                        free_head        = id;
                        r.ok             = 1'b1;
                    end
                end
                fla_pkg::MODE_LOOKUP: begin
                    if (id_ok) begin
                        prod          = (32'(id) - 1) * 32'(elem_bytes);
                        r.byte_offset = prod[fla_pkg::OFF_W-1:0];
                        r.ok          = 1'b1;
                    end
                end
                default: ;
            endcase
            owed_q.push_back(r);
            return r;
        endfunction

        // compare one transferred response with the oldest one owed
        function void check_response(t_alloc_rsp got);
            t_alloc_rsp want;
            if (owed_q.size() == 0) begin
                note_failure($sformatf("response with none owed: id %0d offset %0d ok %0b",
                                       got.granted_id, got.byte_offset, got.ok));
                return;
            end
            want = owed_q.pop_front();
            if (got.granted_id !== want.granted_id || got.byte_offset !== want.byte_offset ||
                got.ok !== want.ok) begin
                note_failure($sformatf("expected id %0d offset %0d ok %0b, got id %0d offset %0d ok %0b",
                                       want.granted_id, want.byte_offset, want.ok,
                                       got.granted_id, got.byte_offset, got.ok));
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [fla_pkg::EB_W-1:0] i_cfg_wdata;

    fla_req_if req_if ();
    fla_rsp_if rsp_if ();

    alloc_scoreboard sb = new();

    int          req_idle_pct;
    int          rsp_idle_pct;
    bit          valid_up;
    logic [fla_pkg::ID_W-1:0] live_ids[$];

    free_list_id_allocator #(
        .POOL_SLOTS (POOL)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response({rsp_if.granted_id, rsp_if.byte_offset, rsp_if.ok});
        end
    end

    // run limit
    initial begin
        #400000;
        $display("** free_list_id_allocator: FAILED **");
        $finish;
    end

    task automatic lower_valid();
        if (valid_up) begin
            req_if.valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // one request transfer, with a random gap ahead of it
    task automatic send_request(input logic [fla_pkg::MODE_W-1:0] mode,
                                input logic [fla_pkg::ID_W-1:0] id,
                                output t_alloc_rsp owed);
        if ($urandom_range(99) < req_idle_pct) begin
            lower_valid();
            @(posedge i_clk);
            while ($urandom_range(99) < req_idle_pct) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.slot_id <= id;
        valid_up = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        owed = sb.note_request(mode, id);
    endtask

    // send and keep the list of ids currently handed out
    task automatic issue(input logic [fla_pkg::MODE_W-1:0] mode,
                         input logic [fla_pkg::ID_W-1:0] id);
        t_alloc_rsp owed;
        int         idx;
        send_request(mode, id, owed);
        idx = -1;
        if (mode == fla_pkg::MODE_CREATE && owed.ok) begin
            live_ids.push_back(owed.granted_id);
        end else if (mode == fla_pkg::MODE_DESTROY && owed.ok) begin
            foreach (live_ids[i]) if (idx < 0 && live_ids[i] == id) idx = i;
            if (idx >= 0) live_ids.delete(idx);
        end
    endtask

    // hold the sender until every owed response has come
    task automatic drain_responses();
        lower_valid();
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_elem_bytes(input logic [fla_pkg::EB_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_elem_bytes(v);
    endtask

    // one random request; loose allows destroys of ids already free
    task automatic random_request(input int create_w, input int destroy_w, input int noise_w,
                                  input bit loose);
        int unsigned r;
        int unsigned k;
        logic [fla_pkg::ID_W-1:0] hw;
        hw = sb.high_water;
        r  = $urandom_range(99);
        if (r < noise_w) begin
            // noise: odd modes and ids out of range
            k = $urandom_range(3);
            if (k == fla_pkg::MODE_DESTROY && !loose) begin
                if ($urandom_range(1)) issue(fla_pkg::MODE_DESTROY, '0);
                else issue(fla_pkg::MODE_DESTROY,
                           fla_pkg::ID_W'($urandom_range(hw + 1, ID_MAX)));
            end else begin
                issue(fla_pkg::MODE_W'(k), fla_pkg::ID_W'($urandom_range(ID_MAX)));
            end
        end else if (r < noise_w + create_w) begin
            issue(fla_pkg::MODE_CREATE, fla_pkg::ID_W'($urandom_range(ID_MAX)));
        end else if (r < noise_w + create_w + destroy_w) begin
            if (loose && hw != 0) begin
                issue(fla_pkg::MODE_DESTROY, fla_pkg::ID_W'($urandom_range(1, hw)));
            end else if (live_ids.size() != 0) begin
                k = $urandom_range(live_ids.size() - 1);
                issue(fla_pkg::MODE_DESTROY, live_ids[k]);
            end else begin
                issue(fla_pkg::MODE_CREATE, fla_pkg::ID_W'($urandom_range(ID_MAX)));
            end
        end else begin
            if (hw != 0) issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'($urandom_range(1, hw)));
            else issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'($urandom_range(ID_MAX)));
        end
    endtask

    // stimulus
    initial begin
        req_idle_pct   = 17;
        rsp_idle_pct   = 53;
        valid_up       = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= fla_pkg::MODE_CREATE;
        req_if.slot_id <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bump, lookups in and out of range, ignored ids, unused mode,
        // pops from the free list back to back
        write_elem_bytes(fla_pkg::EB_RESET);
        issue(fla_pkg::MODE_CREATE, '0);
        issue(fla_pkg::MODE_CREATE, fla_pkg::ID_W'(ID_MAX));
        issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'(1));
        issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'(2));
        issue(fla_pkg::MODE_LOOKUP, '0);
        issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'(3));
        issue(fla_pkg::MODE_DESTROY, '0);
        issue(fla_pkg::MODE_DESTROY, fla_pkg::ID_W'(ID_MAX));
        issue(MODE_UNUSED, fla_pkg::ID_W'(1));
        issue(MODE_UNUSED, fla_pkg::ID_W'(ID_MAX));
        issue(fla_pkg::MODE_DESTROY, fla_pkg::ID_W'(1));
        issue(fla_pkg::MODE_CREATE, '0);
        issue(fla_pkg::MODE_CREATE, '0);
        issue(fla_pkg::MODE_DESTROY, fla_pkg::ID_W'(3));
        issue(fla_pkg::MODE_DESTROY, fla_pkg::ID_W'(2));
        issue(fla_pkg::MODE_LOOKUP, fla_pkg::ID_W'(2));
        issue(fla_pkg::MODE_CREATE, '0);
        issue(fla_pkg::MODE_CREATE, '0);
        issue(fla_pkg::MODE_CREATE, '0);
        drain_responses();

        // random, well-formed traffic with some noise
        write_elem_bytes(fla_pkg::EB_W'($urandom_range(4, EB_MAX)));
        repeat (150) random_request(40, 30, 15, 1'b0);
        drain_responses();

        // receiver mostly ready, largest element size and offsets near the top
        req_idle_pct = 53;
        rsp_idle_pct = 17;
        write_elem_bytes(fla_pkg::EB_W'(EB_MAX));
        repeat (150) random_request(40, 25, 10, 1'b0);
        issue(fla_pkg::MODE_LOOKUP, sb.high_water);
        issue(fla_pkg::MODE_LOOKUP, sb.high_water + 1'b1);
        issue(fla_pkg::MODE_DESTROY, sb.high_water + 1'b1);
        drain_responses();

        // no idling, small element size, double destroys allowed
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        write_elem_bytes(fla_pkg::EB_W'(1));
        repeat (180) random_request(40, 30, 10, 1'b1);

        drain_responses();
        repeat (20) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.outstanding() == 0) begin
            $display("** free_list_id_allocator: PASSED **");
        end else begin
            $display("** free_list_id_allocator: FAILED **");
        end
        $finish;
    end

endmodule
